// File: src/ths_pkg.sv
// ----------------------------------------------------------------------------
// ths_pkg
// Shared types and constants for the time history averager.
// ----------------------------------------------------------------------------
package ths_pkg;

  localparam int DEPTH    = 8;
  localparam int SAMPLE_W = 32;
  localparam int IDX_W    = 8;
  localparam int ACT_W    = 2;

  localparam int HIDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = SAMPLE_W + $clog2(DEPTH);
  localparam int DIV_CW = $clog2(SUM_W);

  localparam logic [ACT_W-1:0] ACT_PUSH  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]    action;
    logic [IDX_W-1:0]    index;
    logic [SAMPLE_W-1:0] time_value;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] entry_value;
    logic [SAMPLE_W-1:0] average;
  } out_t;

  typedef struct packed {
    logic push;
    logic write;
    logic rotate;
  } hist_ctrl_t;

endpackage

// File: src/ths_history.sv
// ----------------------------------------------------------------------------
// ths_history
// Sample history registers: push, indexed write, and a rotate path that
// presents every entry at the tail once per scan.
// ----------------------------------------------------------------------------
module ths_history (
  input  logic                        clk,
  input  logic                        rst,
  input  ths_pkg::hist_ctrl_t         ctrl,
  input  logic [ths_pkg::HIDX_W-1:0]  wr_index,
  input  logic [ths_pkg::SAMPLE_W-1:0] wr_value,
  input  logic [ths_pkg::HIDX_W-1:0]  rd_index,
  output logic [ths_pkg::SAMPLE_W-1:0] rd_value,
  output logic [ths_pkg::SAMPLE_W-1:0] tail
);
  import ths_pkg::*;

  logic [SAMPLE_W-1:0] history [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) history[i] <= '0;
    end else if (ctrl.push) begin
      for (int i = 1; i < DEPTH; i++) history[i] <= history[i-1];
      history[0] <= wr_value;
    end else if (ctrl.write) begin
      history[wr_index] <= wr_value;
    end else if (ctrl.rotate) begin
      // oldest wraps to newest; a full rotation of all entries restores the order
      for (int i = 1; i < DEPTH; i++) history[i] <= history[i-1];
      history[0] <= history[DEPTH-1];
    end
  end

  assign rd_value = history[rd_index];
  assign tail     = history[DEPTH-1];

endmodule

// File: src/ths_divider.sv
// ----------------------------------------------------------------------------
// ths_divider
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ths_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ths_pkg::SUM_W-1:0]   dividend,
  input  logic [ths_pkg::CNT_W-1:0]   divisor,
  output logic                        done,
  output logic [ths_pkg::SUM_W-1:0]   quotient
);
  import ths_pkg::*;

  logic              busy;
  logic [DIV_CW-1:0] bit_cnt;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;
  logic              take;

  assign shifted = {rem, quo[SUM_W-1]};
  assign diff    = shifted - {1'b0, divisor};
  assign take    = (shifted >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      bit_cnt <= '0;
    end else if (start) begin
      busy    <= 1'b1;
      bit_cnt <= DIV_CW'(SUM_W - 1);
    end else if (busy) begin
      if (bit_cnt == '0) busy <= 1'b0;
      bit_cnt <= bit_cnt - DIV_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[SUM_W-2:0], take};
      rem <= take ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
    end
  end

  assign done     = busy && (bit_cnt == '0);
  assign quotient = quo;

endmodule

// File: src/time_history_averager.sv
// ----------------------------------------------------------------------------
// time_history_averager
// Sample history with push, indexed read/write and a mean of the nonzero entries
// scaled by six.
// a request passes through S_SUM, S_DGO, S_DWAIT and S_OUT in that order
// no new request is taken until the last result is loaded for output; the
//   entry scan takes one entry a cycle, the divider one quotient bit a cycle
// a finished result waits in the output register while the next request runs
// reset: synchronous, clears the history to zero and empties the output
module time_history_averager (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ths_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ths_pkg::out_t  out_data
);
  import ths_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUM   = 3'd1;
  localparam logic [2:0] S_DGO   = 3'd2;
  localparam logic [2:0] S_DWAIT = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]          state;
  logic [HIDX_W-1:0]   step;
  logic [HIDX_W-1:0]   idx;
  logic                idx_ok;
  logic [SUM_W-1:0]    acc;
  logic [CNT_W-1:0]    cnt;
  logic [SAMPLE_W-1:0] entry;

  hist_ctrl_t          hctrl;
  logic [SAMPLE_W-1:0] rd_value;
  logic [SAMPLE_W-1:0] tail;
  logic [SAMPLE_W-1:0] scaled;
  logic                in_fire;
  logic                in_rng;
  logic                div_done;
  logic [SUM_W-1:0]    quotient;
  logic                out_load;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign in_rng   = (in_data.index < IDX_W'(DEPTH));

  always_comb begin
    hctrl.push   = in_fire && (in_data.action == ACT_PUSH);
    hctrl.write  = in_fire && (in_data.action == ACT_WRITE) && in_rng;
    hctrl.rotate = (state == S_SUM);
  end

  ths_history u_hist (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (hctrl),
    .wr_index (in_data.index[HIDX_W-1:0]),
    .wr_value (in_data.time_value),
    .rd_index (idx),
    .rd_value (rd_value),
    .tail     (tail)
  );

  // times six, wrapping to 32 bits
  assign scaled = (tail << 2) + (tail << 1);

  ths_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_DGO),
    .dividend (acc),
    .divisor  (cnt),
    .done     (div_done),
    .quotient (quotient)
  );

  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= S_SUM;
            step  <= '0;
          end
        end
        S_SUM: begin
          if (step == HIDX_W'(DEPTH - 1)) state <= S_DGO;
          step <= step + HIDX_W'(1);
        end
        S_DGO:   state <= S_DWAIT;
        S_DWAIT: if (div_done) state <= S_OUT;
        S_OUT:   if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      idx    <= in_data.index[HIDX_W-1:0];
      idx_ok <= in_rng;
      acc    <= '0;
      cnt    <= '0;
    end else if (state == S_SUM) begin
      // first scan cycle sees the history before any rotation
      if (step == '0) entry <= idx_ok ? rd_value : '0;
      if (tail != '0) begin
        acc <= acc + SUM_W'(scaled);
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.entry_value <= entry;
      out_data.average     <= (cnt == '0) ? '0 : quotient[SAMPLE_W-1:0];
    end
  end

endmodule

// File: src/ths_checker.sv
// ----------------------------------------------------------------------------
// ths_checker
// Port-level checks for the time history averager, bound to the top level.
// ----------------------------------------------------------------------------
module ths_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input ths_pkg::in_t   in_data,
  input logic           out_valid,
  input logic           out_ready,
  input ths_pkg::out_t  out_data
);
  import ths_pkg::*;

  // reset leaves the output empty and the input open
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("output not empty or input closed after reset");

  // a taken request closes the input
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input open right after a request");

  // no result can appear the cycle after a request
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared too early");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind time_history_averager ths_checker u_ths_checker (.*);

// File: verif/tb_time_history_averager.sv
// ----------------------------------------------------------------------------
// tb_time_history_averager
// Drives pushes, indexed writes and reads into the sample history and checks
// every returned entry and scaled nonzero-entry mean against a shadow history kept
// here, with random gaps on both handshakes and one long output stall.
// ----------------------------------------------------------------------------
module tb_time_history_averager;
  timeunit 1ns;
  timeprecision 1ps;

  import ths_pkg::*;

  // unused action code, behaves as a read
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

  localparam int RANDOM_REQS  = 1728;
  localparam int IDLE_PCT     = 38;
  localparam int BURST_LO     = 700;
  localparam int BURST_HI     = 1000;
  localparam int STALL_AT     = 300;
  localparam int STALL_CYCLES = 500;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  in_t  pending_reqs[$];
  out_t predicted_outs[$];
  logic [SAMPLE_W-1:0] history_shadow[DEPTH];

  int fail_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int push_count = 0;
  int write_count = 0;
  int read_count = 0;
  int oob_count = 0;
  int stall_left = 0;
  bit stall_done = 1'b0;

  time_history_averager dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // update the shadow history and return the entry and the scaled mean
  function automatic out_t apply_request(in_t req);
    out_t res;
    logic [63:0] total;
    logic [SAMPLE_W-1:0] scaled;
    int nonzero;
    int k;
    bit hit;
    hit = req.index < DEPTH;
    case (req.action)
      ACT_PUSH: begin
        for (k = DEPTH - 1; k >= 1; k--) history_shadow[k] = history_shadow[k - 1];
        history_shadow[0] = req.time_value;
      end
      ACT_WRITE: begin
        if (hit) history_shadow[req.index] = req.time_value;
      end
      default: ;
    endcase
    res.entry_value = '0;
    if (hit) res.entry_value = history_shadow[req.index];
    total = '0;
    nonzero = 0;
    for (k = 0; k < DEPTH; k++) begin
      if (history_shadow[k] != '0) begin
        // product wraps at 32 bits, entry still counts even if it wraps to 0
        scaled = history_shadow[k] * 32'd6;
        total += scaled;
        nonzero++;
      end
    end
    res.average = (nonzero == 0) ? '0 : SAMPLE_W'(total / nonzero);
    return res;
  endfunction

  function automatic in_t make_req(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                                   logic [SAMPLE_W-1:0] val);
    in_t r;
    r.action = act;
    r.index = idx;
    r.time_value = val;
    return r;
  endfunction

  function automatic in_t random_req();
    in_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) r.action = ACT_PUSH;
    else if (pick < 75) r.action = ACT_WRITE;
    else if (pick < 95) r.action = ACT_READ;
    else r.action = ACT_SPARE;
    if ($urandom_range(0, 99) < 80) r.index = IDX_W'($urandom_range(0, DEPTH - 1));
    else r.index = IDX_W'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      r.time_value = '0;
    end else if (pick < 35) begin
      case ($urandom_range(0, 4))
        0: r.time_value = 32'hFFFF_FFFF;
        1: r.time_value = 32'h8000_0000;
        2: r.time_value = 32'h2AAA_AAAA;
        3: r.time_value = 32'h2AAA_AAAB;
        default: r.time_value = 32'd1;
      endcase
    end else if (pick < 60) begin
      r.time_value = $urandom_range(1, 1000);
    end else begin
      r.time_value = $urandom;
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    in_t   nxt;
    out_t  res;
    bit    quiet;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        res = apply_request(in_data);
        predicted_outs.push_back(res);
        sent_count++;
        case (in_data.action)
          ACT_PUSH:  push_count++;
          ACT_WRITE: write_count++;
          default:   read_count++;
        endcase
        if (in_data.index >= DEPTH) oob_count++;
      end
      if (!in_valid || in_ready) begin
        quiet = (sent_count >= BURST_LO && sent_count < BURST_HI);
        if (pending_reqs.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_data <= nxt;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long output hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (!stall_done && checked_count == STALL_AT) begin
      stall_left <= STALL_CYCLES;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    out_t exp_res;
    bit   quiet;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_outs.size() == 0) begin
          $error("result with nothing outstanding: entry_value %h average %h",
                 out_data.entry_value, out_data.average);
          fail_count++;
        end else begin
          exp_res = predicted_outs.pop_front();
          if (out_data.entry_value !== exp_res.entry_value) begin
            $error("entry_value mismatch: expected %h, actual %h",
                   exp_res.entry_value, out_data.entry_value);
            fail_count++;
          end
          if (out_data.average !== exp_res.average) begin
            $error("average mismatch: expected %h, actual %h",
                   exp_res.average, out_data.average);
            fail_count++;
          end
        end
        checked_count++;
      end
      quiet = (checked_count >= BURST_LO && checked_count < BURST_HI);
      out_ready <= (stall_left == 0) && (quiet || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    int k;
    for (k = 0; k < DEPTH; k++) history_shadow[k] = '0;

    // empty history, out-of-range reads, spare action code, ignored writes
    pending_reqs.push_back(make_req(ACT_READ, 8'd0, 32'h1234_5678));
    pending_reqs.push_back(make_req(ACT_READ, 8'd255, 32'h0));
    pending_reqs.push_back(make_req(ACT_SPARE, IDX_W'(DEPTH - 1), 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(ACT_WRITE, IDX_W'(DEPTH), 32'hDEAD_BEEF));
    pending_reqs.push_back(make_req(ACT_WRITE, 8'd255, 32'hFFFF_FFFF));
    // sample whose scaled value wraps to zero but still counts
    pending_reqs.push_back(make_req(ACT_PUSH, 8'd0, 32'h8000_0000));
    // push reports the entry at index after the shift
    pending_reqs.push_back(make_req(ACT_PUSH, 8'd1, 32'd1));
    pending_reqs.push_back(make_req(ACT_PUSH, IDX_W'(DEPTH - 1), 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(ACT_WRITE, IDX_W'(DEPTH - 1), 32'h2AAA_AAAA));
    pending_reqs.push_back(make_req(ACT_WRITE, 8'd0, 32'h0));
    pending_reqs.push_back(make_req(ACT_READ, 8'd3, 32'h5555_5555));
    // full history of the largest sample, each scaled value wrapping to 32 bits
    for (k = 0; k < DEPTH; k++)
      pending_reqs.push_back(make_req(ACT_PUSH, IDX_W'(k), 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(ACT_WRITE, IDX_W'(DEPTH - 1), 32'h0));
    pending_reqs.push_back(make_req(ACT_READ, IDX_W'(DEPTH), 32'hAAAA_AAAA));
    pending_reqs.push_back(make_req(ACT_PUSH, 8'd0, 32'h0));
    for (k = 0; k < RANDOM_REQS; k++) pending_reqs.push_back(random_req());

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (predicted_outs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (predicted_outs.size() != 0) begin
      $error("%0d results never arrived", predicted_outs.size());
      fail_count++;
    end

    $display("run covered %0d requests: %0d pushes, %0d writes, %0d reads, %0d out of range",
             sent_count, push_count, write_count, read_count, oob_count);
    $display("%0d results compared, %0d errors", checked_count, fail_count);
    if (fail_count == 0) begin
      $display("** time_history_averager: PASSED **");
    end else begin
      $display("** time_history_averager: FAILED **");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("** time_history_averager: FAILED **");
    $finish;
  end

endmodule
